// ----- sv/dvs_pkg.sv -----
package dvs_pkg;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_H       = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING_KEEP = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPRING_K     = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH  = 8'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_MASS     = 8'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GRAVITY      = 8'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIND_AMP     = 8'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WIND_DECAY   = 8'd7;

	localparam logic [31:0]        RST_STEP_H       = 32'd655;
	localparam logic [16:0]        RST_DAMPING_KEEP = 17'd65405;
	localparam logic [31:0]        RST_SPRING_K     = 32'd19661;
	localparam logic [30:0]        RST_REST_LENGTH  = 31'd13107200;
	localparam logic [31:0]        RST_INV_MASS     = 32'd32768;
	localparam logic signed [31:0] RST_GRAVITY      = 32'sd642253;
	localparam logic signed [31:0] RST_WIND_AMP     = 32'sd655360;
	localparam logic [16:0]        RST_WIND_DECAY   = 17'd65503;

	localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

	typedef struct packed {
		logic [31:0]        step_h;
		logic [16:0]        damping_keep;
		logic [31:0]        spring_k;
		logic [30:0]        rest_length;
		logic [31:0]        inv_mass;
		logic signed [31:0] gravity;
		logic signed [31:0] wind_amp;
		logic [16:0]        wind_decay;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic done;
	} iter_ctl_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v[65:31] == '0 || v[65:31] == '1) r = v[31:0];
		else if (v[65]) r = SAT_MIN;
		else r = SAT_MAX;
		return r;
	endfunction

endpackage

// ----- sv/dvs_ifs.sv -----
interface dvs_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [31:0] x_init;
	logic signed [31:0] y_init;
	modport source (output valid, output operation, output x_init, output y_init, input ready);
	modport sink (input valid, input operation, input x_init, input y_init, output ready);
endinterface

interface dvs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_pos;
	logic signed [31:0] y_pos;
	logic [31:0]        sim_time;
	modport source (output valid, output x_pos, output y_pos, output sim_time, input ready);
	modport sink (input valid, input x_pos, input y_pos, input sim_time, output ready);
endinterface

interface dvs_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/dvs_cfg.sv -----
module dvs_cfg import dvs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dvs_cfg_if.sink cfg,
	output cfg_t regs
);
	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.step_h       <= RST_STEP_H;
			regs_q.damping_keep <= RST_DAMPING_KEEP;
			regs_q.spring_k     <= RST_SPRING_K;
			regs_q.rest_length  <= RST_REST_LENGTH;
			regs_q.inv_mass     <= RST_INV_MASS;
			regs_q.gravity      <= RST_GRAVITY;
			regs_q.wind_amp     <= RST_WIND_AMP;
			regs_q.wind_decay   <= RST_WIND_DECAY;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_STEP_H:       regs_q.step_h       <= cfg.data;
				REG_DAMPING_KEEP: regs_q.damping_keep <= cfg.data[16:0];
				REG_SPRING_K:     regs_q.spring_k     <= cfg.data;
				REG_REST_LENGTH:  regs_q.rest_length  <= cfg.data[30:0];
				REG_INV_MASS:     regs_q.inv_mass     <= cfg.data;
				REG_GRAVITY:      regs_q.gravity      <= $signed(cfg.data);
				REG_WIND_AMP:     regs_q.wind_amp     <= $signed(cfg.data);
				REG_WIND_DECAY:   regs_q.wind_decay   <= cfg.data[16:0];
				default: ;
			endcase
		end
	end
endmodule

// ----- sv/dvs_mul.sv -----
module dvs_mul (
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] prod
);
	logic signed [65:0] prod_q;

	assign prod = prod_q;

	always_ff @(posedge clk) begin
		if (en) prod_q <= a * b;
	end
endmodule

// ----- sv/dvs_root.sv -----
module dvs_root import dvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  iter_ctl_t   ctl_in,
	output iter_ctl_t   ctl_out,
	input  logic [63:0] rad,
	output logic [31:0] root
);
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] rem_sh;
	logic [34:0] trial;
	logic        take;

	assign rem_sh = {rem_q[32:0], rad_q[63:62]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign take   = rem_sh >= trial;
	assign root   = root_q;
	assign ctl_out.start = busy_q;
	assign ctl_out.done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (take) begin
				rem_q  <= 34'(rem_sh - trial);
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[33:0];
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end
endmodule

// ----- sv/dvs_div.sv -----
module dvs_div import dvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  iter_ctl_t   ctl_in,
	output iter_ctl_t   ctl_out,
	input  logic [62:0] num,
	input  logic [31:0] den,
	output logic [31:0] quo
);
	logic [31:0] rem_q;
	logic [31:0] lo_q;
	logic [31:0] den_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic        take;

	assign rem_sh = {rem_q, lo_q[31]};
	assign take   = rem_sh >= {1'b0, den_q};
	assign quo    = quo_q;
	assign ctl_out.start = busy_q;
	assign ctl_out.done  = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rem_q <= {1'b0, num[62:32]};
			lo_q  <= num[31:0];
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			lo_q  <= {lo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], take};
			if (take) rem_q <= 32'(rem_sh - {1'b0, den_q});
			else rem_q <= rem_sh[31:0];
		end
	end
endmodule

// ----- sv/damped_verlet_spring_step_top.sv -----
// channel | dir | handshake   | payload
// item    | in  | valid/ready | operation, x_init, y_init
// result  | out | valid/ready | x_pos, y_pos, sim_time
// cfg     | in  | valid/ready | index, data (ready always high)
// A load item goes from its transfer through S_PUSH back to ready; a step runs the square
// root, two division passes through the single divider and 13 passes through the single
// 33x33 multiplier before it reaches S_PUSH.
// arst_n clears the sequencer, the position state and the result valid flag.
// item.ready is high only while the sequencer is idle; a stalled result holds
// the sequencer before its last transfer.
module damped_verlet_spring_step_top import dvs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	dvs_in_if.sink    item,
	dvs_out_if.source result,
	dvs_cfg_if.sink   cfg
);
	typedef enum logic [20:0] {
		S_IDLE  = 21'h000001,
		S_MXX   = 21'h000002,
		S_MYY   = 21'h000004,
		S_RAD   = 21'h000008,
		S_ROOT  = 21'h000010,
		S_ERR   = 21'h000020,
		S_MT    = 21'h000040,
		S_MH    = 21'h000080,
		S_MNX   = 21'h000100,
		S_MNY   = 21'h000200,
		S_DINIT = 21'h000400,
		S_DIV   = 21'h000800,
		S_MAX   = 21'h001000,
		S_MAY   = 21'h002000,
		S_MKX   = 21'h004000,
		S_MKY   = 21'h008000,
		S_MDX   = 21'h010000,
		S_MDY   = 21'h020000,
		S_MW    = 21'h040000,
		S_UPD   = 21'h080000,
		S_PUSH  = 21'h100000
	} state_t;

	state_t state_q;
	cfg_t   regs;

	logic signed [31:0] cx_q, cy_q, px_q, py_q, wind_q;
	logic [31:0]        elapsed_q;
	logic [63:0]        acc_q;
	logic [31:0]        mag_q;
	logic               eneg_q;
	logic signed [31:0] tension_q;
	logic [31:0]        h2_q;
	logic signed [65:0] numx_q;
	logic               axis_q;
	logic               dneg_q;
	logic signed [32:0] fsx_q, fsy_q;
	logic signed [31:0] ax_q, ay_q;
	logic signed [35:0] vkx_q, vky_q;
	logic signed [31:0] nx_q, ny_q;
	logic signed [31:0] xo_q, yo_q;
	logic [31:0]        to_q;
	logic               ov_q;

	logic               mul_en;
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;
	iter_ctl_t          root_ctl, root_st, div_ctl, div_st;
	logic [31:0]        root;
	logic [31:0]        quo;
	logic signed [65:0] num_sel;
	logic signed [65:0] num_abs;
	logic signed [32:0] err;
	logic [32:0]        time_sum;
	logic signed [32:0] fs_new;
	logic               slot_free;
	logic               accept;

	dvs_cfg u_cfg (.clk(clk), .arst_n(arst_n), .cfg(cfg), .regs(regs));

	dvs_mul u_mul (.clk(clk), .en(mul_en), .a(mul_a), .b(mul_b), .prod(prod));

	dvs_root u_root (
		.clk(clk), .arst_n(arst_n), .ctl_in(root_ctl), .ctl_out(root_st),
		.rad(acc_q + prod[63:0]), .root(root)
	);

	dvs_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl_in(div_ctl), .ctl_out(div_st),
		.num(num_abs[62:0]), .den(root), .quo(quo)
	);

	assign item.ready      = state_q == S_IDLE;
	assign accept          = item.valid && item.ready;
	assign result.valid    = ov_q;
	assign result.x_pos    = xo_q;
	assign result.y_pos    = yo_q;
	assign result.sim_time = to_q;
	assign slot_free       = !ov_q || result.ready;

	assign root_ctl.start = state_q == S_RAD;
	assign root_ctl.done  = 1'b0;
	assign div_ctl.start  = state_q == S_DINIT;
	assign div_ctl.done   = 1'b0;

	assign num_sel  = axis_q ? prod : numx_q;
	assign num_abs  = num_sel[65] ? -num_sel : num_sel;
	assign err      = $signed({1'b0, root}) - $signed({2'b00, regs.rest_length});
	assign time_sum = {1'b0, elapsed_q} + {1'b0, regs.step_h};
	assign fs_new   = (root == '0) ? 33'sd0 :
		(dneg_q ? $signed({1'b0, quo}) : -$signed({1'b0, quo}));

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			S_MXX: begin
				mul_a = 33'(cx_q);
				mul_b = 33'(cx_q);
			end
			S_MYY: begin
				mul_a = 33'(cy_q);
				mul_b = 33'(cy_q);
			end
			S_MT: begin
				mul_a = $signed({1'b0, regs.spring_k});
				mul_b = $signed({1'b0, mag_q});
			end
			S_MH: begin
				mul_a = $signed({1'b0, regs.step_h});
				mul_b = $signed({1'b0, regs.step_h});
			end
			S_MNX: begin
				mul_a = 33'(tension_q);
				mul_b = 33'(cx_q);
			end
			S_MNY: begin
				mul_a = 33'(tension_q);
				mul_b = 33'(cy_q);
			end
			S_MAX: begin
				mul_a = 33'(sat32(66'(fsx_q) + 66'(wind_q)));
				mul_b = $signed({1'b0, regs.inv_mass});
			end
			S_MAY: begin
				mul_a = 33'(sat32(66'(fsy_q)));
				mul_b = $signed({1'b0, regs.inv_mass});
			end
			S_MKX: begin
				mul_a = $signed({16'd0, regs.damping_keep});
				mul_b = 33'(cx_q) - 33'(px_q);
			end
			S_MKY: begin
				mul_a = $signed({16'd0, regs.damping_keep});
				mul_b = 33'(cy_q) - 33'(py_q);
			end
			S_MDX: begin
				mul_a = 33'(ax_q);
				mul_b = $signed({1'b0, h2_q});
			end
			S_MDY: begin
				mul_a = 33'(ay_q);
				mul_b = $signed({1'b0, h2_q});
			end
			S_MW: begin
				mul_a = 33'(wind_q);
				mul_b = $signed({16'd0, regs.wind_decay});
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ov_q      <= 1'b0;
			cx_q      <= '0;
			cy_q      <= '0;
			px_q      <= '0;
			py_q      <= '0;
			elapsed_q <= '0;
			wind_q    <= RST_WIND_AMP;
			axis_q    <= 1'b0;
		end else begin
			ov_q <= (state_q == S_PUSH && slot_free) || (ov_q && !result.ready);
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.operation == OP_LOAD) begin
							cx_q      <= item.x_init;
							px_q      <= item.x_init;
							cy_q      <= item.y_init;
							py_q      <= item.y_init;
							elapsed_q <= '0;
							wind_q    <= regs.wind_amp;
							state_q   <= S_PUSH;
						end else begin
							state_q <= S_MXX;
						end
					end
				end
				S_MXX: state_q <= S_MYY;
				S_MYY: state_q <= S_RAD;
				S_RAD: state_q <= S_ROOT;
				S_ROOT: if (root_st.done) state_q <= S_ERR;
				S_ERR: state_q <= S_MT;
				S_MT: state_q <= S_MH;
				S_MH: state_q <= S_MNX;
				S_MNX: state_q <= S_MNY;
				S_MNY: begin
					axis_q  <= 1'b0;
					state_q <= S_DINIT;
				end
				S_DINIT: state_q <= S_DIV;
				S_DIV: begin
					if (div_st.done) begin
						if (axis_q) begin
							state_q <= S_MAX;
						end else begin
							axis_q  <= 1'b1;
							state_q <= S_DINIT;
						end
					end
				end
				S_MAX: state_q <= S_MAY;
				S_MAY: state_q <= S_MKX;
				S_MKX: state_q <= S_MKY;
				S_MKY: state_q <= S_MDX;
				S_MDX: state_q <= S_MDY;
				S_MDY: state_q <= S_MW;
				S_MW: state_q <= S_UPD;
				S_UPD: begin
					px_q      <= cx_q;
					py_q      <= cy_q;
					cx_q      <= nx_q;
					cy_q      <= ny_q;
					elapsed_q <= time_sum[32] ? 32'hffffffff : time_sum[31:0];
					wind_q    <= sat32(prod >>> 16);
					state_q   <= S_PUSH;
				end
				S_PUSH: begin
					if (slot_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_MYY: acc_q <= prod[63:0];
			S_ERR: begin
				eneg_q <= err[32];
				mag_q  <= err[32] ? 32'(-err) : err[31:0];
			end
			S_MH: begin
				if (|prod[63:47]) tension_q <= eneg_q ? SAT_MIN : SAT_MAX;
				else if (eneg_q) tension_q <= -$signed(prod[47:16]);
				else tension_q <= $signed(prod[47:16]);
			end
			S_MNX: h2_q <= (|prod[63:48]) ? 32'hffffffff : prod[47:16];
			S_MNY: numx_q <= prod;
			S_DINIT: dneg_q <= num_sel[65];
			S_DIV: begin
				if (div_st.done) begin
					if (axis_q) fsy_q <= fs_new;
					else fsx_q <= fs_new;
				end
			end
			S_MAY: ax_q <= sat32(prod >>> 16);
			S_MKX: ay_q <= sat32(66'(sat32(prod >>> 16)) + 66'(regs.gravity));
			S_MKY: vkx_q <= 36'(prod >>> 16);
			S_MDX: vky_q <= 36'(prod >>> 16);
			S_MDY: nx_q <= sat32(66'(cx_q) + 66'(vkx_q) + (prod >>> 16));
			S_MW: ny_q <= sat32(66'(cy_q) + 66'(vky_q) + (prod >>> 16));
			S_PUSH: begin
				if (slot_free) begin
					xo_q <= cx_q;
					yo_q <= cy_q;
					to_q <= elapsed_q;
				end
			end
			default: ;
		endcase
	end
endmodule

// ----- test/damped_verlet_spring_step_top_test.sv -----
`timescale 1ns / 1ps

module damped_verlet_spring_step_top_test;
	import dvs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'hff;
	localparam int IDLE_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 200;
	localparam int LONG_HOLD = 600;

	typedef struct {
		logic               operation;
		logic signed [31:0] x_init;
		logic signed [31:0] y_init;
	} sim_item_t;

	typedef struct {
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic [31:0]        sim_time;
	} sim_pos_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dvs_in_if  item_if ();
	dvs_out_if res_if ();
	dvs_cfg_if cfg_if ();

	damped_verlet_spring_step_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	always #5 clk = ~clk;

	// register image and body state
	longint unsigned r_step_h, r_keep, r_k, r_rest, r_inv_mass, r_decay;
	longint          r_gravity, r_wind_amp;
	longint          body_x, body_y, body_px, body_py, wind_force;
	longint unsigned body_time;

	sim_item_t pending_items[$];
	sim_pos_t  expected_pos[$];

	int errors = 0;
	int loads_sent = 0;
	int steps_sent = 0;
	int positions_checked = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int stall_mode = 0;
	int mode_left = 0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned int_root(longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint spring_force(longint tension, longint c, longint unsigned d);
		if (d == 0) return 0;
		return -((tension * c) / longint'(d));
	endfunction

	function automatic longint verlet_move(longint c, longint p, longint a, longint unsigned h2);
		longint vk, dx;
		vk = (longint'(r_keep) * (c - p)) >>> 16;
		dx = (a * longint'(h2)) >>> 16;
		return clamp32(c + vk + dx);
	endfunction

	function automatic void reset_body_model();
		r_step_h = RST_STEP_H;
		r_keep = RST_DAMPING_KEEP;
		r_k = RST_SPRING_K;
		r_rest = RST_REST_LENGTH;
		r_inv_mass = RST_INV_MASS;
		r_gravity = RST_GRAVITY;
		r_wind_amp = RST_WIND_AMP;
		r_decay = RST_WIND_DECAY;
		body_x = 0;
		body_y = 0;
		body_px = 0;
		body_py = 0;
		body_time = 0;
		wind_force = RST_WIND_AMP;
	endfunction

	function automatic void apply_reg(logic [7:0] idx, logic [31:0] data);
		case (idx)
			REG_STEP_H:       r_step_h = data;
			REG_DAMPING_KEEP: r_keep = data[16:0];
			REG_SPRING_K:     r_k = data;
			REG_REST_LENGTH:  r_rest = data[30:0];
			REG_INV_MASS:     r_inv_mass = data;
			REG_GRAVITY:      r_gravity = longint'(signed'(data));
			REG_WIND_AMP:     r_wind_amp = longint'(signed'(data));
			REG_WIND_DECAY:   r_decay = data[16:0];
			default: ;
		endcase
	endfunction

	function automatic sim_pos_t next_position(sim_item_t it);
		sim_pos_t res;
		longint unsigned sq, d, mag, tm, h2;
		longint e, tension, fsx, fsy, ax, ay, nx, ny;
		if (it.operation == OP_LOAD) begin
			body_x = it.x_init;
			body_px = it.x_init;
			body_y = it.y_init;
			body_py = it.y_init;
			body_time = 0;
			wind_force = r_wind_amp;
		end else begin
			sq = longint'(body_x * body_x);
			sq = sq + longint'(body_y * body_y);
			d = int_root(sq);
			e = longint'(d) - longint'(r_rest);
			mag = (e >= 0) ? e : -e;
			tm = (r_k * mag) >> 16;
			if (e >= 0) tension = (tm > 64'd2147483647) ? 64'sd2147483647 : longint'(tm);
			else tension = (tm > 64'd2147483647) ? -64'sd2147483648 : -longint'(tm);
			fsx = spring_force(tension, body_x, d);
			fsy = spring_force(tension, body_y, d);
			ax = clamp32((clamp32(fsx + wind_force) * longint'(r_inv_mass)) >>> 16);
			ay = clamp32(clamp32((clamp32(fsy) * longint'(r_inv_mass)) >>> 16) + r_gravity);
			h2 = (r_step_h * r_step_h) >> 16;
			if (h2 > 64'hffff_ffff) h2 = 64'hffff_ffff;
			nx = verlet_move(body_x, body_px, ax, h2);
			ny = verlet_move(body_y, body_py, ay, h2);
			body_px = body_x;
			body_py = body_y;
			body_x = nx;
			body_y = ny;
			body_time = body_time + r_step_h;
			if (body_time > 64'hffff_ffff) body_time = 64'hffff_ffff;
			wind_force = clamp32((wind_force * longint'(r_decay)) >>> 16);
		end
		res.x_pos = body_x[31:0];
		res.y_pos = body_y[31:0];
		res.sim_time = body_time[31:0];
		return res;
	endfunction

	// driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		sim_item_t it;
		if (!arst_n) begin
			item_if.valid <= 1'b0;
			item_if.operation <= OP_LOAD;
			item_if.x_init <= '0;
			item_if.y_init <= '0;
		end else begin
			if (item_if.valid && item_if.ready) begin
				it.operation = item_if.operation;
				it.x_init = item_if.x_init;
				it.y_init = item_if.y_init;
				expected_pos.push_back(next_position(it));
				if (it.operation == OP_LOAD) loads_sent++;
				else steps_sent++;
			end
			if (!item_if.valid || item_if.ready) begin
				if (gap_left > 0 || pending_items.size() == 0) begin
					item_if.valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end else begin
					it = pending_items.pop_front();
					item_if.valid <= 1'b1;
					item_if.operation <= it.operation;
					item_if.x_init <= it.x_init;
					item_if.y_init <= it.y_init;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
					end
				end
			end
		end
	end

	// monitor: compare each result transfer and drive a stall pattern
	always @(posedge clk or negedge arst_n) begin
		sim_pos_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (expected_pos.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					want = expected_pos.pop_front();
					positions_checked++;
					if (res_if.x_pos !== want.x_pos) begin
						$error("x_pos expected %0d got %0d", want.x_pos, res_if.x_pos);
						errors++;
					end
					if (res_if.y_pos !== want.y_pos) begin
						$error("y_pos expected %0d got %0d", want.y_pos, res_if.y_pos);
						errors++;
					end
					if (res_if.sim_time !== want.sim_time) begin
						$error("sim_time expected %0d got %0d", want.sim_time, res_if.sim_time);
						errors++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 400);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: res_if.ready <= 1'b1;
					1: res_if.ready <= ($urandom_range(0, 3) != 0);
					default: res_if.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("damped_verlet_spring_step_top regression: fail");
			$finish;
		end
	end

	task automatic write_reg(logic [7:0] idx, logic [31:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= data;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		apply_reg(idx, data);
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	// sample between edges so driver and monitor updates have settled
	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_pos.size() != 0 || item_if.valid)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_item(logic op, logic [31:0] x, logic [31:0] y);
		sim_item_t it;
		it.operation = op;
		it.x_init = x;
		it.y_init = y;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] pick_word(logic [31:0] typical, logic [31:0] top);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return top;
			2: return $urandom() & top;
			default: return ($urandom_range(0, 3) == 0) ? (typical ^ ($urandom() & 32'hff)) : typical;
		endcase
	endfunction

	task automatic random_settings();
		write_reg(REG_STEP_H, ($urandom_range(0, 4) == 0) ? pick_word(655, 32'hffff_ffff)
			: $urandom_range(1, 4000));
		write_reg(REG_DAMPING_KEEP, pick_word(65405, 32'h1_ffff));
		write_reg(REG_SPRING_K, pick_word(19661, 32'hffff_ffff));
		write_reg(REG_REST_LENGTH, pick_word(13107200, 32'h7fff_ffff));
		write_reg(REG_INV_MASS, pick_word(32768, 32'hffff_ffff));
		write_reg(REG_GRAVITY, ($urandom_range(0, 2) == 0) ? $urandom() : 642253);
		write_reg(REG_WIND_AMP, ($urandom_range(0, 2) == 0) ? $urandom() : 655360);
		write_reg(REG_WIND_DECAY, pick_word(65503, 32'h1_ffff));
		write_reg(REG_UNUSED, $urandom());
	endtask

	task automatic random_run(int count);
		for (int i = 0; i < count; i++) begin
			if (i == 0 || $urandom_range(0, 40) == 0) begin
				if ($urandom_range(0, 4) == 0)
					queue_item(OP_LOAD, $urandom(), $urandom());
				else
					queue_item(OP_LOAD, $signed($urandom_range(0, 2000000)) - 1000000,
						$signed($urandom_range(0, 2000000)) - 1000000);
			end else begin
				queue_item(OP_STEP, $urandom(), $urandom());
			end
		end
	endtask

	initial begin
		reset_body_model();
		cfg_if.valid = 1'b0;
		cfg_if.index = '0;
		cfg_if.data = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_item(OP_STEP, 32'h0, 32'h0);
		queue_item(OP_LOAD, 32'h0, 32'h0);
		queue_item(OP_STEP, 32'hffff_ffff, 32'hffff_ffff);
		queue_item(OP_STEP, 32'h0, 32'h0);
		queue_item(OP_LOAD, 32'h8000_0000, 32'h7fff_ffff);
		repeat (3) queue_item(OP_STEP, 32'h0, 32'h0);
		queue_item(OP_LOAD, 32'h7fff_ffff, 32'h8000_0000);
		repeat (3) queue_item(OP_STEP, 32'h5555_5555, 32'haaaa_aaaa);
		queue_item(OP_LOAD, 32'd13107200, 32'h0);
		repeat (3) queue_item(OP_STEP, 32'h0, 32'h0);
		queue_item(OP_LOAD, 32'h0, 32'hff38_0000);
		repeat (4) queue_item(OP_STEP, 32'h0, 32'h0);
		wait_drained();

		write_reg(REG_STEP_H, 32'hffff_ffff);
		write_reg(REG_DAMPING_KEEP, 32'h1_ffff);
		write_reg(REG_SPRING_K, 32'hffff_ffff);
		write_reg(REG_REST_LENGTH, 32'h0);
		write_reg(REG_INV_MASS, 32'hffff_ffff);
		write_reg(REG_GRAVITY, 32'h8000_0000);
		write_reg(REG_WIND_AMP, 32'h7fff_ffff);
		write_reg(REG_WIND_DECAY, 32'h1_ffff);
		queue_item(OP_LOAD, 32'h0001_0000, 32'hffff_0000);
		repeat (4) queue_item(OP_STEP, 32'h0, 32'h0);
		wait_drained();

		write_reg(REG_STEP_H, 32'h0);
		write_reg(REG_DAMPING_KEEP, 32'h0);
		write_reg(REG_SPRING_K, 32'h0);
		write_reg(REG_REST_LENGTH, 32'h7fff_ffff);
		write_reg(REG_INV_MASS, 32'h0);
		write_reg(REG_GRAVITY, 32'h7fff_ffff);
		write_reg(REG_WIND_AMP, 32'h8000_0000);
		write_reg(REG_WIND_DECAY, 32'h0);
		queue_item(OP_LOAD, 32'h0000_8000, 32'h0);
		repeat (3) queue_item(OP_STEP, 32'h0, 32'h0);
		wait_drained();

		for (int phase = 0; phase < 9; phase++) begin
			if (phase == 0) begin
				write_reg(REG_STEP_H, RST_STEP_H);
				write_reg(REG_DAMPING_KEEP, RST_DAMPING_KEEP);
				write_reg(REG_SPRING_K, RST_SPRING_K);
				write_reg(REG_REST_LENGTH, RST_REST_LENGTH);
				write_reg(REG_INV_MASS, RST_INV_MASS);
				write_reg(REG_GRAVITY, RST_GRAVITY);
				write_reg(REG_WIND_AMP, RST_WIND_AMP);
				write_reg(REG_WIND_DECAY, RST_WIND_DECAY);
			end else begin
				random_settings();
			end
			if (phase == 2) hold_left = LONG_HOLD;
			random_run(185);
			wait_drained();
		end

		if (expected_pos.size() != 0) begin
			$error("%0d positions never arrived", expected_pos.size());
			errors++;
		end
		$display("covered %0d loads and %0d steps, %0d positions checked, %0d mismatches",
			loads_sent, steps_sent, positions_checked, errors);
		if (errors == 0)
			$display("damped_verlet_spring_step_top regression: pass");
		else
			$display("damped_verlet_spring_step_top regression: fail");
		$finish;
	end

endmodule
